// ===== hw/rtl/wbfd_pkg.sv =====
package wbfd_pkg;

    localparam int MaxRawBytes = 512;
    localparam int CntW        = 10;
    localparam int OutDataW    = 112;
    localparam int FifoDepth   = 4;
    localparam int PtrW        = 2;

    localparam logic [7:0]  ByteEsc    = 8'hFC;
    localparam logic [7:0]  ByteMsg    = 8'hFD;
    localparam logic [7:0]  ByteSys    = 8'hFE;
    localparam logic [7:0]  ByteDisc   = 8'hF8;
    localparam logic [15:0] CrcPoly    = 16'h1002;
    localparam logic [15:0] CrcInit    = 16'hF1E2;

    localparam logic [2:0] StOk      = 3'd0;
    localparam logic [2:0] StTooLong = 3'd1;
    localparam logic [2:0] StBadLen  = 3'd2;
    localparam logic [2:0] StCrcFail = 3'd3;
    localparam logic [2:0] StUnknown = 3'd4;
    localparam logic [2:0] StEmpty   = 3'd5;

    localparam logic [2:0] TyNone    = 3'd0;
    localparam logic [2:0] TyInfo    = 3'd1;
    localparam logic [2:0] TyAck     = 3'd2;
    localparam logic [2:0] TyDisc    = 3'd3;
    localparam logic [2:0] TySystem  = 3'd4;
    localparam logic [2:0] TyDiscRsp = 3'd5;

    typedef struct packed {
        logic                last;
        logic [OutDataW-1:0] data;
    } result_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] t;
        logic        top;
        t = {crc[15:8] ^ b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            top = t[15];
            t   = {t[14:0], 1'b0};
            if (top) begin
                t = t ^ CrcPoly;
            end
        end
        return {crc[7:0], 8'h00} ^ t;
    endfunction

    function automatic logic is_payload(input logic [CntW-1:0] j, input logic [7:0] start,
                                        input logic [7:0] len);
        logic r;
        r = 1'b0;
        if (start == ByteMsg) begin
            r = (j >= CntW'(11)) && (len >= 8'd2);
        end else if (start == ByteSys) begin
            r = (j >= CntW'(4)) && (len >= 8'd2);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/wired_bus_frame_decoder_core.sv =====
// Frame decoder for a byte-stuffed wired bus.
// Input stream: one raw frame byte per item on s_tdata, s_tlast on the final
// byte of the frame. Output stream: payload items (m_tlast low, data byte in
// the low bits) followed by one summary item per frame (m_tlast high) that
// carries status and, for a good frame, frame type, header fields and checksum.
// Each input item is decoded in the cycle it is accepted, and its results
// (none, one, or up to three on the final byte) are written into a
// four-entry result queue that drives the m_ side. The first result is
// in the queue from the cycle after the item is accepted.
// Throughput is one input item per cycle; s_tready stays high while the
// queue holds at most one entry, so one result taken per cycle keeps the
// input flowing. A closing item may add three results, which can stall the
// input while the queue drains.
// When the receiver stalls, the queue fills and s_tready drops; nothing is
// lost. Synchronous reset (aresetn low) empties the queue, clears all frame
// state and sets unescaping on. cfg_we writes the unescape enable bit.
module wired_bus_frame_decoder_core import wbfd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // in_byte
    input  logic                s_tlast,   // end_of_frame
    output logic                m_tvalid,
    input  logic                m_tready,
    // data_byte[7:0], status[10:8], frame_type[13:11], dest_addr[45:14],
    // sender_addr[77:46], control_byte[85:78], send_counter[87:86],
    // recv_counter[89:88], sync_bit[90], addr_mask[95:91], checksum[111:96]
    output logic [OutDataW-1:0] m_tdata,
    output logic                m_tlast    // last
);

    logic             unesc_reg;
    logic             esc_reg, esc_next;
    logic             too_long_reg, too_long_next;
    logic [CntW-1:0]  raw_cnt_reg, raw_cnt_next;
    logic [CntW-1:0]  idx_reg, idx_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       held0_reg, held0_next, held1_reg, held1_next;
    logic [31:0]      dest_reg, dest_next, sender_reg, sender_next;
    logic [7:0]       ctrl_reg, ctrl_next, len_reg, len_next, start_reg, start_next;

    result_t          fifo_reg [FifoDepth];
    logic [PtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]    count_reg;

    logic             s_fire, m_fire;
    result_t          res [3];
    logic [1:0]       n_res;

    assign s_tready = (count_reg <= (PtrW+1)'(1));
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = fifo_reg[rd_ptr_reg].data;
    assign m_tlast  = fifo_reg[rd_ptr_reg].last;

    always_comb begin
        logic [7:0]      b;
        logic [2:0]      st, ty;
        logic [31:0]     f_dest, f_sender;
        logic [1:0]      f_send, f_recv;
        logic            f_sync;
        logic [4:0]      f_mask;
        logic [15:0]     f_crc, rx, c2;
        logic [7:0]      c;
        logic [CntW-1:0] n, len_ext;
        logic            use_crc, crc_present, payload_frame;

        esc_next      = esc_reg;
        too_long_next = too_long_reg;
        raw_cnt_next  = raw_cnt_reg;
        idx_next      = idx_reg;
        crc_next      = crc_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        dest_next     = dest_reg;
        sender_next   = sender_reg;
        ctrl_next     = ctrl_reg;
        len_next      = len_reg;
        start_next    = start_reg;
        n_res         = 2'd0;
        for (int k = 0; k < 3; k++) begin
            res[k] = '0;
        end
        b             = s_tdata;
        st            = StOk;
        ty            = TyNone;
        f_dest        = '0;
        f_sender      = '0;
        f_send        = '0;
        f_recv        = '0;
        f_sync        = 1'b0;
        f_mask        = '0;
        f_crc         = '0;
        rx            = '0;
        c2            = '0;
        c             = '0;
        n             = '0;
        len_ext       = '0;
        use_crc       = 1'b0;
        crc_present   = 1'b0;
        payload_frame = 1'b0;

        if (s_fire) begin
            if (!too_long_reg) begin
                if (raw_cnt_reg >= CntW'(MaxRawBytes)) begin
                    too_long_next = 1'b1;
                end else begin
                    raw_cnt_next = raw_cnt_reg + CntW'(1);
                    if (unesc_reg && s_tdata == ByteEsc) begin
                        esc_next = 1'b1;
                    end else begin
                        if (esc_reg) begin
                            b = s_tdata | 8'h80;
                        end
                        esc_next = 1'b0;
                        if (!s_tlast && idx_reg >= CntW'(1)
                            && is_payload(idx_reg - CntW'(1), start_reg, len_reg)) begin
                            res[0].data[7:0] = held1_reg;
                            n_res = 2'd1;
                        end
                        // Header capture by decoded position.
                        if (idx_reg == '0) begin
                            start_next = b;
                        end else if (start_reg == ByteMsg) begin
                            if (idx_reg <= CntW'(4)) begin
                                dest_next = {dest_reg[23:0], b};
                            end else if (idx_reg == CntW'(5)) begin
                                ctrl_next = b;
                            end else if (idx_reg <= CntW'(9)) begin
                                if (idx_reg == CntW'(6)) begin
                                    len_next = b;
                                end
                                sender_next = {sender_reg[23:0], b};
                            end else if (idx_reg == CntW'(10)) begin
                                len_next = b;
                            end
                        end else if (start_reg == ByteSys) begin
                            if (idx_reg == CntW'(1)) begin
                                dest_next = {24'h0, b};
                            end else if (idx_reg == CntW'(2)) begin
                                ctrl_next = b;
                            end else if (idx_reg == CntW'(3)) begin
                                len_next = b;
                            end
                        end
                        // The CRC trails the stream by two bytes so that a
                        // received CRC is never folded into itself.
                        if (idx_reg >= CntW'(2)) begin
                            crc_next = crc_step(crc_reg, held0_reg);
                        end
                        held0_next = held1_reg;
                        held1_next = b;
                        if (idx_reg != {CntW{1'b1}}) begin
                            idx_next = idx_reg + CntW'(1);
                        end
                    end
                end
            end

            if (s_tlast) begin
                n       = idx_next;
                c       = ctrl_next;
                len_ext = CntW'(len_next);
                if (too_long_next) begin
                    st = StTooLong;
                end else if (n == '0) begin
                    st = StEmpty;
                end else if (esc_next) begin
                    st = StBadLen;
                end else if (start_next == ByteMsg) begin
                    if (n >= CntW'(11)) begin
                        if (n != len_ext + CntW'(11) && n != len_ext + CntW'(9)) begin
                            st = StBadLen;
                        end else begin
                            ty = c[0] ? TyAck : TyInfo;
                            if (!c[0]) begin
                                f_send = c[2:1];
                                f_sync = c[7];
                            end
                            f_recv = c[6:5];
                            if (c[3]) begin
                                f_sender = sender_next;
                            end
                            f_dest = dest_next;
                            if (len_next >= 8'd2) begin
                                use_crc       = 1'b1;
                                payload_frame = 1'b1;
                                crc_present   = (n == len_ext + CntW'(11));
                            end
                        end
                    end else if (n == CntW'(9) || n == CntW'(7)) begin
                        if (c[1:0] == 2'b00) begin
                            st = StBadLen;
                        end else begin
                            ty     = TyDisc;
                            f_dest = dest_next;
                            f_mask = c[7:3];
                            if (len_next == 8'd2) begin
                                use_crc     = 1'b1;
                                crc_present = (n == CntW'(9));
                            end
                        end
                    end else begin
                        st = StBadLen;
                    end
                end else if (start_next == ByteSys) begin
                    if (n > CntW'(3)) begin
                        ty     = TySystem;
                        f_dest = dest_next;
                        f_recv = c[6:5];
                        if (len_next >= 8'd2) begin
                            use_crc       = 1'b1;
                            payload_frame = 1'b1;
                            crc_present   = (n == len_ext + CntW'(4));
                        end
                    end else begin
                        st = StUnknown;
                    end
                end else if (start_next == ByteDisc && n == CntW'(1)) begin
                    ty = TyDiscRsp;
                end else begin
                    st = StUnknown;
                end

                if (st == StOk && use_crc) begin
                    if (crc_present) begin
                        rx = {held0_next, held1_next};
                        if (crc_next != rx) begin
                            st = StCrcFail;
                        end else begin
                            f_crc = rx;
                        end
                    end else begin
                        c2 = crc_next;
                        if (n >= CntW'(2)) begin
                            c2 = crc_step(c2, held0_next);
                        end
                        f_crc = crc_step(c2, held1_next);
                    end
                end

                // Without a CRC the two held bytes are payload too.
                if (st == StOk && payload_frame && !crc_present) begin
                    if (n >= CntW'(2) && is_payload(n - CntW'(2), start_next, len_next)) begin
                        res[n_res].data[7:0] = held0_next;
                        n_res = n_res + 2'd1;
                    end
                    if (is_payload(n - CntW'(1), start_next, len_next)) begin
                        res[n_res].data[7:0] = held1_next;
                        n_res = n_res + 2'd1;
                    end
                end

                res[n_res].last = 1'b1;
                if (st == StOk) begin
                    res[n_res].data = {f_crc, f_mask, f_sync, f_recv, f_send, c,
                                       f_sender, f_dest, ty, st, 8'h00};
                end else begin
                    res[n_res].data = '0;
                    res[n_res].data[10:8] = st;
                end
                n_res = n_res + 2'd1;

                esc_next      = 1'b0;
                too_long_next = 1'b0;
                raw_cnt_next  = '0;
                idx_next      = '0;
                crc_next      = CrcInit;
                held0_next    = '0;
                held1_next    = '0;
                dest_next     = '0;
                sender_next   = '0;
                ctrl_next     = '0;
                len_next      = '0;
                start_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unesc_reg    <= 1'b1;
            esc_reg      <= 1'b0;
            too_long_reg <= 1'b0;
            raw_cnt_reg  <= '0;
            idx_reg      <= '0;
            crc_reg      <= CrcInit;
            held0_reg    <= '0;
            held1_reg    <= '0;
            dest_reg     <= '0;
            sender_reg   <= '0;
            ctrl_reg     <= '0;
            len_reg      <= '0;
            start_reg    <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unesc_reg <= cfg_wdata;
            end
            esc_reg      <= esc_next;
            too_long_reg <= too_long_next;
            raw_cnt_reg  <= raw_cnt_next;
            idx_reg      <= idx_next;
            crc_reg      <= crc_next;
            held0_reg    <= held0_next;
            held1_reg    <= held1_next;
            dest_reg     <= dest_next;
            sender_reg   <= sender_next;
            ctrl_reg     <= ctrl_next;
            len_reg      <= len_next;
            start_reg    <= start_next;
            wr_ptr_reg   <= wr_ptr_reg + PtrW'(n_res);
            rd_ptr_reg   <= rd_ptr_reg + PtrW'(m_fire);
            count_reg    <= count_reg + (PtrW+1)'(n_res) - (PtrW+1)'(m_fire);
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < n_res) begin
                fifo_reg[wr_ptr_reg + PtrW'(k)] <= res[k];
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PtrW+1)'(FifoDepth))
        else $error("result queue overfilled");

    a_mid_frame_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !s_tlast && !m_fire |=> count_reg <= $past(count_reg) + (PtrW+1)'(1))
        else $error("mid-frame item produced more than one result");

    a_close_adds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast && !m_fire |=> count_reg > $past(count_reg))
        else $error("closing item produced no summary");

    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> idx_reg == '0 && raw_cnt_reg == '0 && crc_reg == CrcInit)
        else $error("frame state not cleared after closing item");
`endif

endmodule
